FILE: rtl/three_band_biquad_eq_with_ramp_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three band equalizer
// Shared property wrappers clocked on i_clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef THREE_BAND_BIQUAD_EQ_WITH_RAMP_UNIT_DEFINES_SVH
`define THREE_BAND_BIQUAD_EQ_WITH_RAMP_UNIT_DEFINES_SVH

// Property that is checked only while reset is released.
`define TBEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tbeq check failed");

// Property that is checked on every edge, reset included.
`define TBEQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tbeq check failed");

`endif

FILE: rtl/tbeq_pkg.sv
// ---------------------------------------------------------------------------
// Three band equalizer package
// Shared constants, register indexes, state type and small lookup functions.
// ---------------------------------------------------------------------------
`default_nettype none

package tbeq_pkg;

    // Default parameter values.
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 21;

    // Storage geometry.
    localparam int NUM_COEFS = 15;
    localparam int NUM_WORDS = 5;
    localparam int NUM_DELAY = 6;
    localparam int COEF_AW   = 4;
    localparam int DLY_AW    = 3;
    localparam int DLY_W     = 32;
    localparam int SLOT_BITS = 21;

    // Configuration port.
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int RAMP_W    = 16;
    localparam int THR_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RAMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLAT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR  = 3'd7;

    localparam logic [RAMP_W-1:0] RST_RAMP = 16'd16384;
    localparam logic [THR_W-1:0]  RST_THR  = 20'd4;
    localparam int                RND_HALF = 32768;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_RDEC,
        ST_SNAP,
        ST_FILT,
        ST_OUT
    } t_state;

    // True for the b0 entry of each band, which resets to unity.
    function automatic logic is_coef_b0(input logic [COEF_AW-1:0] addr);
        logic res;
        unique case (addr)
            4'd0, 4'd5, 4'd10: res = 1'b1;
            default:           res = 1'b0;
        endcase
        return res;
    endfunction

    // Coefficient offset within a band for each multiply step of a band:
    // b0*x, b1*x, a1*y, b2*x, a2*y.
    function automatic logic [2:0] op_coef(input logic [2:0] op);
        logic [2:0] res;
        unique case (op)
            3'd0:    res = 3'd0;
            3'd1:    res = 3'd1;
            3'd2:    res = 3'd3;
            3'd3:    res = 3'd2;
            3'd4:    res = 3'd4;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tbeq_in_if.sv
// ---------------------------------------------------------------------------
// Equalizer input channel
// Valid/ready channel carrying one input sample word.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbeq_in_if #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_start;

    modport source (output valid, output sample_in, output block_start, input ready);
    modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/tbeq_out_if.sv
// ---------------------------------------------------------------------------
// Equalizer output channel
// Valid/ready channel carrying one equalized sample word with status flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbeq_out_if #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           bypassed;
    logic                           ramping;

    modport source (output valid, output sample_out, output bypassed, output ramping,
                    input ready);
    modport sink   (input valid, input sample_out, input bypassed, input ramping,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/tbeq_ram.sv
// ---------------------------------------------------------------------------
// Equalizer state memory
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tbeq_ram #(
    parameter int WIDTH = tbeq_pkg::DLY_W,
    parameter int DEPTH = tbeq_pkg::NUM_DELAY,
    parameter int AW    = tbeq_pkg::DLY_AW
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: rtl/three_band_biquad_eq_with_ramp_unit.sv
// ---------------------------------------------------------------------------
// Three band biquad equalizer with coefficient ramp
// Low shelf, peak and high shelf biquads in cascade over a coefficient
// memory and a delay memory, with per-block ramping toward target values.
// ---------------------------------------------------------------------------
// Usage:
//  - i_in carries one sample word (sample_in, block_start); o_out returns one
//    word per input word (sample_out, bypassed, ramping), in order.
//  - Target coefficients, ramp factor, flat flag and snap threshold are
//    written on the i_cfg_* port while the block is idle.
//  - A bypassed word (flat target, no ramp running) skips the filter and
//    goes to the output register. A filtered word passes three bands of five
//    multiplies, each through the single coefficient read port.
//  - A block start on a filtered word adds a ramp pass (a read-modify-write
//    of each coefficient, plus the decision), and a snap pass when the
//    coefficients snap to target, one memory write per cycle.
//  - The next word is accepted as soon as the previous result sits in the
//    output register; a stalled receiver holds that register and the block
//    waits with its finished result until it is taken.
//  - Synchronous reset restores identity coefficients, zero delay state,
//    default configuration and an empty output register; memory contents
//    are covered by per-entry valid bits, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module three_band_biquad_eq_with_ramp_unit #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = tbeq_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tbeq_in_if.sink                             i_in,
    tbeq_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tbeq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tbeq_pkg::CFG_W-1:0]     i_cfg_data
);
    import tbeq_pkg::*;

    localparam int FRAC    = COEF_WIDTH - 4;
    localparam int PROD_W  = COEF_WIDTH + DLY_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SUM_W   = ACC_W - FRAC + 2;
    localparam int MAG_W   = COEF_WIDTH;
    localparam int DIFF_W  = COEF_WIDTH + 1;
    localparam int RPROD_W = MAG_W + RAMP_W;
    localparam int CMP_W   = (MAG_W > THR_W) ? MAG_W : THR_W;

    localparam logic [CFG_W-1:0]      ONE_W   = CFG_W'(1) << FRAC;
    localparam logic [COEF_WIDTH-1:0] ONE_C   = COEF_WIDTH'(1) << FRAC;
    localparam logic [ACC_W:0]        ACC_HLF = (ACC_W + 1)'(1) << (FRAC - 1);

    // Configuration registers.
    logic [CFG_W-1:0]  r_cw [NUM_WORDS];
    logic [RAMP_W-1:0] r_k;
    logic              r_flat;
    logic [THR_W-1:0]  r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw[0] <= ONE_W;
            r_cw[1] <= ONE_W << (2 * SLOT_BITS);
            r_cw[2] <= '0;
            r_cw[3] <= ONE_W << SLOT_BITS;
            r_cw[4] <= '0;
            r_k     <= RST_RAMP;
            r_flat  <= 1'b1;
            r_thr   <= RST_THR;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_IDX_W'(NUM_WORDS)) begin
                r_cw[i_cfg_idx] <= i_cfg_data;
            end else if (i_cfg_idx == CFG_IDX_RAMP) begin
                r_k <= i_cfg_data[RAMP_W-1:0];
            end else if (i_cfg_idx == CFG_IDX_FLAT) begin
                r_flat <= i_cfg_data[0];
            end else if (i_cfg_idx == CFG_IDX_THR) begin
                r_thr <= i_cfg_data[THR_W-1:0];
            end
        end
    end

    // Target coefficients unpacked from the configuration words.
    logic [COEF_WIDTH-1:0] w_tgt [NUM_COEFS];
    for (genvar gi = 0; gi < NUM_COEFS; gi++) begin : g_tgt
        assign w_tgt[gi] = r_cw[gi / 3][(gi % 3) * SLOT_BITS +: COEF_WIDTH];
    end

    // Sequencer registers.
    t_state              r_st, n_st;
    logic [COEF_AW-1:0]  r_idx, n_idx;
    logic [1:0]          r_ph, n_ph;
    logic [2:0]          r_op, n_op;
    logic [1:0]          r_band, n_band;
    logic                r_run, n_run;
    logic                r_byp, n_byp;
    logic [NUM_COEFS-1:0] r_cvld, n_cvld;
    logic [NUM_DELAY-1:0] r_dvld, n_dvld;

    // Datapath registers.
    logic signed [DLY_W-1:0]  r_v, n_v;
    logic signed [DLY_W-1:0]  r_y, n_y;
    logic signed [DLY_W-1:0]  r_z, n_z;
    logic signed [PROD_W-1:0] r_mprod, n_mprod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic [COEF_WIDTH-1:0]    r_cur, n_cur;
    logic [RPROD_W-1:0]       r_rprod, n_rprod;
    logic [MAG_W-1:0]         r_gap, n_gap;

    // Output register.
    logic                    r_ov, n_ov;
    logic [SAMPLE_WIDTH-1:0] r_osmp, n_osmp;
    logic                    r_obyp, n_obyp;
    logic                    r_oramp, n_oramp;

    // Memory ports.
    logic                  c_we;
    logic [COEF_AW-1:0]    c_waddr, c_raddr, r_cq;
    logic [COEF_WIDTH-1:0] c_wdata, c_rdata;
    logic                  d_we;
    logic [DLY_AW-1:0]     d_waddr, d_raddr, r_dq;
    logic [DLY_W-1:0]      d_wdata, d_rdata;

    tbeq_ram #(.WIDTH(COEF_WIDTH), .DEPTH(NUM_COEFS), .AW(COEF_AW)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    tbeq_ram #(.WIDTH(DLY_W), .DEPTH(NUM_DELAY), .AW(DLY_AW)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // Read data with never-written entries replaced by their reset value.
    logic signed [COEF_WIDTH-1:0] w_cur;
    logic signed [DLY_W-1:0]      w_zrd;
    assign w_cur = r_cvld[r_cq] ? c_rdata : (is_coef_b0(r_cq) ? ONE_C : '0);
    assign w_zrd = r_dvld[r_dq] ? d_rdata : '0;

    // Ramp arithmetic.
    logic [COEF_WIDTH-1:0]    w_tsel;
    logic signed [DIFF_W-1:0] w_diff;
    logic [MAG_W-1:0]         w_mag;
    logic [RPROD_W:0]         w_rsum;
    logic [MAG_W-1:0]         w_st;
    logic [COEF_WIDTH-1:0]    w_new;
    logic [MAG_W-1:0]         w_rgap;
    assign w_tsel = w_tgt[r_idx];
    assign w_diff = DIFF_W'($signed(w_tsel)) - DIFF_W'(w_cur);
    assign w_mag  = w_diff[DIFF_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
    assign w_rsum = {1'b0, r_rprod} + (RPROD_W + 1)'(RND_HALF);
    assign w_st   = w_rsum[RAMP_W +: MAG_W];
    assign w_new  = r_neg ? (r_cur - w_st) : (r_cur + w_st);
    assign w_rgap = r_mag - w_st;

    // Filter arithmetic.
    logic                      w_yop;
    logic signed [DLY_W-1:0]   w_oper;
    logic signed [PROD_W-1:0]  w_ce, w_oe;
    logic signed [ACC_W:0]     w_accx;
    logic signed [ACC_W-FRAC:0] w_rnd;
    logic signed [DLY_W-1:0]   w_zadd;
    logic signed [SUM_W-1:0]   w_sum;
    logic [SUM_W-DLY_W:0]      w_top;
    logic [DLY_W-1:0]          w_sat;
    logic [DLY_W-SAMPLE_WIDTH:0] w_ytop;
    logic [SAMPLE_WIDTH-1:0]   w_ysat;
    assign w_yop  = (r_op == 3'd2) || (r_op == 3'd4);
    assign w_oper = w_yop ? r_y : r_v;
    assign w_ce   = PROD_W'(w_cur);
    assign w_oe   = PROD_W'(w_oper);
    assign w_accx = (ACC_W + 1)'(r_acc) + $signed(ACC_HLF);
    assign w_rnd  = w_accx[ACC_W:FRAC];
    assign w_zadd = (r_op == 3'd4) ? '0 : r_z;
    assign w_sum  = SUM_W'(w_rnd) + SUM_W'(w_zadd);
    assign w_top  = w_sum[SUM_W-1:DLY_W-1];
    assign w_sat  = ((&w_top) || !(|w_top)) ? w_sum[DLY_W-1:0]
                  : {w_sum[SUM_W-1], {(DLY_W - 1){~w_sum[SUM_W-1]}}};
    assign w_ytop = r_y[DLY_W-1:SAMPLE_WIDTH-1];
    assign w_ysat = ((&w_ytop) || !(|w_ytop)) ? r_y[SAMPLE_WIDTH-1:0]
                  : {r_y[DLY_W-1], {(SAMPLE_WIDTH - 1){~r_y[DLY_W-1]}}};

    // Handshake outputs.
    assign i_in.ready       = (r_st == ST_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_osmp;
    assign o_out.bypassed   = r_obyp;
    assign o_out.ramping    = r_oramp;

    // Next state, memory control and datapath updates.
    always_comb begin
        n_st    = r_st;
        n_idx   = r_idx;
        n_ph    = r_ph;
        n_op    = r_op;
        n_band  = r_band;
        n_run   = r_run;
        n_byp   = r_byp;
        n_cvld  = r_cvld;
        n_dvld  = r_dvld;
        n_v     = r_v;
        n_y     = r_y;
        n_z     = r_z;
        n_mprod = r_mprod;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_cur   = r_cur;
        n_rprod = r_rprod;
        n_gap   = r_gap;
        n_ov    = r_ov;
        n_osmp  = r_osmp;
        n_obyp  = r_obyp;
        n_oramp = r_oramp;
        c_we    = 1'b0;
        c_waddr = r_idx;
        c_wdata = w_new;
        c_raddr = r_idx;
        d_we    = 1'b0;
        d_waddr = {r_band, 1'b0};
        d_wdata = w_sat;
        d_raddr = {r_band, 1'b0} + {2'b00, (r_op == 3'd2)};

        // The output word leaves when the receiver takes it.
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_st)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_v    = DLY_W'(i_in.sample_in);
                    n_ph   = '0;
                    n_idx  = '0;
                    n_op   = '0;
                    n_band = '0;
                    n_gap  = '0;
                    if (r_flat && !r_run) begin
                        n_y   = DLY_W'(i_in.sample_in);
                        n_byp = 1'b1;
                        n_st  = ST_OUT;
                    end else begin
                        n_byp = 1'b0;
                        n_st  = i_in.block_start ? ST_RAMP : ST_FILT;
                    end
                end
            end

            // Each coefficient in turn: read, difference, scale, write.
            ST_RAMP: begin
                n_ph = r_ph + 2'd1;
                unique case (r_ph)
                    2'd0: ;
                    2'd1: begin
                        n_neg = w_diff[DIFF_W-1];
                        n_mag = w_mag;
                        n_cur = w_cur;
                    end
                    2'd2: begin
                        n_rprod = RPROD_W'(r_mag) * RPROD_W'(r_k);
                    end
                    default: begin
                        c_we           = 1'b1;
                        n_cvld[r_idx]  = 1'b1;
                        if (w_rgap > r_gap) begin
                            n_gap = w_rgap;
                        end
                        if (r_idx == COEF_AW'(NUM_COEFS - 1)) begin
                            n_st = ST_RDEC;
                        end else begin
                            n_idx = r_idx + COEF_AW'(1);
                        end
                    end
                endcase
            end

            // Snap when the largest remaining gap is within the threshold.
            ST_RDEC: begin
                n_idx = '0;
                n_ph  = '0;
                if (CMP_W'(r_gap) <= CMP_W'(r_thr)) begin
                    n_st = ST_SNAP;
                end else begin
                    n_run = 1'b1;
                    n_st  = ST_FILT;
                end
            end

            ST_SNAP: begin
                c_we          = 1'b1;
                c_wdata       = w_tsel;
                n_cvld[r_idx] = 1'b1;
                if (r_idx == COEF_AW'(NUM_COEFS - 1)) begin
                    n_run = !r_flat;
                    n_st  = ST_FILT;
                end else begin
                    n_idx = r_idx + COEF_AW'(1);
                end
            end

            // Five multiplies per band, each through read, multiply, accumulate and write-back phases.
            ST_FILT: begin
                c_raddr = {r_band, 2'b00} + {2'b00, r_band} + {1'b0, op_coef(r_op)};
                n_ph    = r_ph + 2'd1;
                unique case (r_ph)
                    2'd0: ;
                    2'd1: begin
                        n_mprod = w_ce * w_oe;
                        n_z     = w_zrd;
                    end
                    2'd2: begin
                        n_acc = w_yop ? (r_acc - ACC_W'(r_mprod)) : ACC_W'(r_mprod);
                    end
                    default: begin
                        n_op = r_op + 3'd1;
                        if (r_op == 3'd0) begin
                            n_y = w_sat;
                        end else if (r_op == 3'd2) begin
                            d_we         = 1'b1;
                            d_waddr      = {r_band, 1'b0};
                            n_dvld[d_waddr] = 1'b1;
                        end else if (r_op == 3'd4) begin
                            d_we         = 1'b1;
                            d_waddr      = {r_band, 1'b1};
                            n_dvld[d_waddr] = 1'b1;
                            n_op         = '0;
                            n_v          = r_y;
                            n_band       = r_band + 2'd1;
                            if (r_band == 2'd2) begin
                                n_st = ST_OUT;
                            end
                        end
                    end
                endcase
            end

            // Load the output register once it is free or its word is being taken.
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_osmp  = w_ysat;
                    n_obyp  = r_byp;
                    n_oramp = r_byp ? 1'b0 : r_run;
                    n_st    = ST_IDLE;
                end
            end

            default: n_st = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_idx  <= '0;
            r_ph   <= '0;
            r_op   <= '0;
            r_band <= '0;
            r_run  <= 1'b0;
            r_cvld <= '0;
            r_dvld <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_idx  <= n_idx;
            r_ph   <= n_ph;
            r_op   <= n_op;
            r_band <= n_band;
            r_run  <= n_run;
            r_cvld <= n_cvld;
            r_dvld <= n_dvld;
            r_ov   <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_byp   <= n_byp;
        r_v     <= n_v;
        r_y     <= n_y;
        r_z     <= n_z;
        r_mprod <= n_mprod;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_cur   <= n_cur;
        r_rprod <= n_rprod;
        r_gap   <= n_gap;
        r_osmp  <= n_osmp;
        r_obyp  <= n_obyp;
        r_oramp <= n_oramp;
        r_cq    <= c_raddr;
        r_dq    <= d_raddr;
    end
endmodule

`default_nettype wire

FILE: rtl/tbeq_chk.sv
// ---------------------------------------------------------------------------
// Equalizer port checker
// Port-level properties of the equalizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "three_band_biquad_eq_with_ramp_unit_defines.svh"

module tbeq_chk #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::DEF_SAMPLE_WIDTH
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] i_sample_out,
    input wire logic                    i_bypassed,
    input wire logic                    i_ramping
);
    // Reset empties the output register.
    `TBEQ_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid)

    // A word is worked on alone: ready drops after each acceptance.
    `TBEQ_ASSERT(a_one_at_a_time, i_in_valid && i_in_ready |=> !i_in_ready)

    // A bypassed word never reports a running ramp.
    `TBEQ_ASSERT(a_bypass_idle, i_out_valid && i_bypassed |-> !i_ramping)

    // A stalled result word holds.
    `TBEQ_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample_out))
endmodule

bind three_band_biquad_eq_with_ramp_unit tbeq_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tbeq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample_out (o_out.sample_out),
    .i_bypassed   (o_out.bypassed),
    .i_ramping    (o_out.ramping)
);

`default_nettype wire

FILE: test/tb_three_band_biquad_eq_with_ramp_unit.sv
// ---------------------------------------------------------------------------
// Testbench for the three band biquad equalizer with coefficient ramp
// A directed table covers bypass, identity filtering, ramp extremes and
// saturation, then randomized register settings drive sample streams.
// Every output word is checked against a table value or a cycle-free software equalizer.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_three_band_biquad_eq_with_ramp_unit;
    import tbeq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = DEF_SAMPLE_WIDTH;
    localparam int CFRAC = DEF_COEF_WIDTH - 4;
    localparam longint DMAX = 64'sd2147483647;
    localparam longint DMIN = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD4 = 3'd4;

    typedef struct {
        logic signed [SW-1:0] smp;
        bit                   byp;
        bit                   rmp;
    } eq_word_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic signed [SW-1:0]  smp;
        bit                    bs;
        bit                    typed;
        eq_word_t              want;
    } plan_row_t;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tbeq_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    tbeq_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    three_band_biquad_eq_with_ramp_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Equalizer shadow: configuration, live coefficients, delay line, flag.
    logic [CFG_W-1:0]  tgt_word [NUM_WORDS];
    logic [RAMP_W-1:0] ramp_k;
    bit                flat_tgt;
    logic [THR_W-1:0]  snap_thr;
    longint            live_c [NUM_COEFS];
    longint            dly [NUM_DELAY];
    bit                run_flag;

    eq_word_t  pending_q [$];
    eq_word_t  got;
    int        n_err = 0;
    int        n_filt = 0;
    int        n_byp = 0;
    int        n_cfg_sets = 0;
    bit        idle_on = 1'b1;
    int        rx_hold = 0;
    plan_row_t plan [$];

    // Clock.
    initial begin
        i_clk = 1'b0;
    end
    always #1 i_clk = ~i_clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Round a Q4.17 product sum to the sample LSB; >>> floors on longint.
    function automatic longint rnd_q(longint acc);
        return (acc + (64'sd1 <<< (CFRAC - 1))) >>> CFRAC;
    endfunction

    function automatic longint target_c(int i);
        logic signed [DEF_COEF_WIDTH-1:0] t;
        t = tgt_word[i / 3][(i % 3) * SLOT_BITS +: DEF_COEF_WIDTH];
        return longint'(t);
    endfunction

    function automatic longint band_run(int b, longint x);
        longint y;
        longint n1;
        longint n2;
        y  = clamp(rnd_q(live_c[b*5] * x) + dly[b*2], DMIN, DMAX);
        n1 = clamp(rnd_q(live_c[b*5+1] * x - live_c[b*5+3] * y) + dly[b*2+1], DMIN, DMAX);
        n2 = clamp(rnd_q(live_c[b*5+2] * x - live_c[b*5+4] * y), DMIN, DMAX);
        dly[b*2]   = n1;
        dly[b*2+1] = n2;
        return y;
    endfunction

    // One coefficient ramp step followed by the snap decision.
    function automatic void ramp_coefs();
        longint gap;
        longint d;
        longint mag;
        longint st;
        gap = 0;
        for (int i = 0; i < NUM_COEFS; i++) begin
            d   = target_c(i) - live_c[i];
            mag = d < 0 ? -d : d;
            st  = (mag * longint'(ramp_k) + RND_HALF) >>> 16;
            live_c[i] += (d < 0) ? -st : st;
            d   = target_c(i) - live_c[i];
            mag = d < 0 ? -d : d;
            if (mag > gap) gap = mag;
        end
        if (gap <= longint'(snap_thr)) begin
            for (int i = 0; i < NUM_COEFS; i++) live_c[i] = target_c(i);
            run_flag = !flat_tgt;
        end else begin
            run_flag = 1'b1;
        end
    endfunction

    function automatic eq_word_t equalize(logic signed [SW-1:0] smp, bit bs);
        eq_word_t r;
        longint   y;
        if (flat_tgt && !run_flag) begin
            r.smp = smp;
            r.byp = 1'b1;
            r.rmp = 1'b0;
            return r;
        end
        if (bs) ramp_coefs();
        y = band_run(0, longint'(smp));
        y = band_run(1, y);
        y = band_run(2, y);
        y = clamp(y, -(64'sd1 <<< (SW-1)), (64'sd1 <<< (SW-1)) - 1);
        r.smp = y[SW-1:0];
        r.byp = 1'b0;
        r.rmp = run_flag;
        return r;
    endfunction

    function automatic void shadow_reset();
        tgt_word[0] = 63'd1 << CFRAC;
        tgt_word[1] = (63'd1 << CFRAC) << (2 * SLOT_BITS);
        tgt_word[2] = '0;
        tgt_word[3] = (63'd1 << CFRAC) << SLOT_BITS;
        tgt_word[4] = '0;
        ramp_k   = RST_RAMP;
        flat_tgt = 1'b1;
        snap_thr = RST_THR;
        for (int i = 0; i < NUM_COEFS; i++) live_c[i] = (i % 5 == 0) ? (64'sd1 <<< CFRAC) : 0;
        for (int i = 0; i < NUM_DELAY; i++) dly[i] = 0;
        run_flag = 1'b0;
    endfunction

    // Register write on the configuration port, mirrored into the shadow.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx < NUM_WORDS) tgt_word[idx] = data;
        else if (idx == CFG_IDX_RAMP) ramp_k = data[RAMP_W-1:0];
        else if (idx == CFG_IDX_FLAT) flat_tgt = data[0];
        else if (idx == CFG_IDX_THR) snap_thr = data[THR_W-1:0];
    endtask

    // Offer one sample word, with an occasional idle burst first.
    task automatic send_word(logic signed [SW-1:0] smp, bit bs, bit typed, eq_word_t want);
        eq_word_t e;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample_in   <= smp;
        in_ch.block_start <= bs;
        e = equalize(smp, bs);
        pending_q.push_back(typed ? want : e);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending_q.size() == 0);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2, 3:    return SW'($signed($urandom_range(0, 8191)) - 4096);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_word(int mode, int w);
        logic [CFG_W-1:0] v;
        logic [SLOT_BITS-1:0] s;
        v = '0;
        for (int k = 0; k < 3; k++) begin
            if (mode == 0) s = SLOT_BITS'($urandom);
            else if (mode == 1) s = SLOT_BITS'($signed($urandom_range(0, 65535)) - 32768);
            else s = '0;
            // Keep b0 near unity so most settings give a usable response.
            if (mode != 0 && (w * 3 + k) % 5 == 0) s = s + SLOT_BITS'(131072);
            v[k*SLOT_BITS +: SLOT_BITS] = s;
        end
        return v;
    endfunction

    function automatic void add_item(logic signed [SW-1:0] smp, bit bs, bit typed,
                                     logic signed [SW-1:0] w_smp, bit w_byp, bit w_rmp);
        plan_row_t r;
        r = '{default: '0};
        r.smp = smp;
        r.bs = bs;
        r.typed = typed;
        r.want.smp = w_smp;
        r.want.byp = w_byp;
        r.want.rmp = w_rmp;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        plan.push_back(r);
    endfunction

    // Receiver: random stalls, plus long holds requested by the main flow.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                rx_hold = $urandom_range(0, 18);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker against the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected word: sample_out %0d", out_ch.sample_out);
                n_err++;
            end else begin
                got = pending_q.pop_front();
                if (out_ch.sample_out !== got.smp) begin
                    $error("sample_out: expected %0d, got %0d", got.smp, out_ch.sample_out);
                    n_err++;
                end
                if (out_ch.bypassed !== got.byp) begin
                    $error("bypassed: expected %0d, got %0d", got.byp, out_ch.bypassed);
                    n_err++;
                end
                if (out_ch.ramping !== got.rmp) begin
                    $error("ramping: expected %0d, got %0d", got.rmp, out_ch.ramping);
                    n_err++;
                end
                if (got.byp) n_byp++;
                else n_filt++;
            end
        end
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Main flow.
    initial begin
        logic signed [SW-1:0] smax;
        logic signed [SW-1:0] smin;
        eq_word_t none;
        int mode;
        int bs_rate;
        smax = {1'b0, {(SW-1){1'b1}}};
        smin = {1'b1, {(SW-1){1'b0}}};
        none = '{default: '0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        in_ch.block_start = 1'b0;
        shadow_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: bypass after reset, identity filtering, ramp extremes.
        add_item(smax, 1'b0, 1'b1, smax, 1'b1, 1'b0);
        add_item(smin, 1'b1, 1'b1, smin, 1'b1, 1'b0);
        add_item('0, 1'b0, 1'b1, '0, 1'b1, 1'b0);
        add_item(-1, 1'b1, 1'b1, -1, 1'b1, 1'b0);
        add_cfg(CFG_IDX_FLAT, 63'd0);
        add_item(24'sh123456, 1'b0, 1'b1, 24'sh123456, 1'b0, 1'b0);
        add_item(smin, 1'b1, 1'b1, smin, 1'b0, 1'b1);
        add_cfg(CFG_IDX_THR, 63'd0);
        add_cfg(CFG_IDX_RAMP, 63'hFFFF);
        add_cfg(CFG_IDX_WORD0, 63'h40000 | (63'd65536 << SLOT_BITS));
        add_item(smax, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_item(smin, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_item('0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_cfg(CFG_IDX_WORD1, 63'h1F0000 | ((63'd1 << CFRAC) << (2 * SLOT_BITS)));
        add_cfg(CFG_IDX_RAMP, 63'd0);
        add_item(24'sh400000, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_item(24'sh001000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_cfg(CFG_IDX_RAMP, 63'd16384);
        add_cfg(CFG_IDX_THR, 63'hFFFFF);
        add_cfg(CFG_IDX_FLAT, 63'd1);
        add_item(24'sh000001, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_item(24'sh55AA55, 1'b0, 1'b1, 24'sh55AA55, 1'b1, 1'b0);
        add_cfg(CFG_IDX_WORD2, {CFG_W{1'b1}});
        add_cfg(CFG_IDX_WORD3, 63'h100000 | (63'h0FFFFF << SLOT_BITS));
        add_cfg(CFG_IDX_WORD4, 63'd0);
        add_cfg(CFG_IDX_FLAT, 63'd0);
        add_cfg(CFG_IDX_THR, 63'd4);
        add_item(smax, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_item(smin, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_item(24'sh2AAAAA, 1'b0, 1'b0, '0, 1'b0, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                cfg_write(plan[i].idx, plan[i].data);
            end else begin
                send_word(plan[i].smp, plan[i].bs, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: a fresh register setting, then a stream of samples.
        for (int seg = 0; seg < 14; seg++) begin
            drain();
            n_cfg_sets++;
            mode = $urandom_range(0, 3);
            for (int w = 0; w < NUM_WORDS; w++)
                cfg_write(3'(w), pick_word(mode == 3 ? 1 : mode, w));
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_IDX_RAMP, {{47{1'b1}}, 16'd0});
                1: cfg_write(CFG_IDX_RAMP, {$urandom, $urandom} | 63'hFFFF);
                default: cfg_write(CFG_IDX_RAMP, {$urandom, $urandom});
            endcase
            cfg_write(CFG_IDX_FLAT, {$urandom, $urandom});
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_IDX_THR, {$urandom, $urandom} & ~63'hFFFFF);
                1: cfg_write(CFG_IDX_THR, {$urandom, $urandom} | 63'hFFFFF);
                2: cfg_write(CFG_IDX_THR, 63'($urandom_range(0, 64)));
                default: cfg_write(CFG_IDX_THR, {$urandom, $urandom});
            endcase
            if (seg >= 11) idle_on = 1'b0;
            // Hold the receiver off so the block fills and stalls its input.
            if (seg == 3 || seg == 8) rx_hold = 600;
            bs_rate = $urandom_range(1, 6);
            for (int n = 0; n < 50; n++)
                send_word(pick_sample(), $urandom_range(0, bs_rate) == 0, 1'b0, none);
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Ran %0d register settings after the directed table; %0d words filtered,",
                 n_cfg_sets, n_filt);
        $display("%0d bypassed, with ramp steps, snaps and saturation along the way.", n_byp);
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
